// File: src/rgbg_pkg.sv
// Package: widths, register indexes, mode codes and divider step for the pixel converter
package rgbg_pkg;

    // Field widths
    localparam int PIX_W  = 8;
    localparam int GAIN_W = 10;
    localparam int VAL_W  = 33;
    localparam int MODE_W = 2;
    localparam int IDX_W  = 3;

    // Datapath widths
    localparam int PROD_W      = PIX_W + GAIN_W;   // one colour times one gain
    localparam int SUM_W       = 20;               // 3 * 255 * 1023 < 2**20
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 30;
    localparam int MUL_W       = SUM_W + RECIP_W;
    localparam int INT_W       = 10;               // intensity never exceeds 782
    localparam int REM_W       = 16;               // (max - min) * 255 fits 16 bits

    // Cycles from an accepted request to its result strobe
    localparam int LATENCY = 5;

    // ceil(2**30 / 1000): exact truncated quotient for every sum below 2**20
    localparam logic [RECIP_W-1:0] RECIP_1000 = 21'd1073742;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_INTENSITY  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SATURATION = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SCALAR     = 2'd2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_RED   = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_GREEN = 3'd2;
    localparam logic [IDX_W-1:0] REG_GAIN_BLUE  = 3'd3;
    localparam logic [IDX_W-1:0] REG_CLAMP_MIN  = 3'd4;
    localparam logic [IDX_W-1:0] REG_CLAMP_MAX  = 3'd5;

    // Restoring divider state: partial remainder, quotient so far, divisor
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [PIX_W-1:0] quo;
        logic [PIX_W-1:0] dvs;
    } div_t;

    // One restoring step for quotient bit 'sh'
    function automatic div_t div_step(div_t d, logic [2:0] sh);
        div_t             r;
        logic [REM_W-1:0] sub;
        r   = d;
        sub = REM_W'(d.dvs) << sh;
        if (d.rem >= sub)
        begin
            r.rem = d.rem - sub;
            r.quo = d.quo | (PIX_W'(1) << sh);
        end
        return r;
    endfunction

endpackage

// File: src/rgb_to_gray_pixel_converter_top.sv
// Top level: five-stage pixel converter (intensity, saturation, clamped scalar)
//
// Usage
//   Request channel: drive red, green, blue, sample and frame_end and raise
//   start; a request is taken at every rising edge with start high and busy
//   low. busy stays low, so one pixel may enter on every clock.
//   Result channel: result_valid pulses for one cycle with value and
//   frame_end_out; results leave in request order, one per request.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
//   register (mode, three gains, clamp bounds); cfg_ready is always high.
//   Change registers only while no request is in flight.
// Timing
//   A request passes the stage 1 to 4 registers and the output register,
//   which raises its result strobe. Throughput is one pixel per clock, set by
//   the five-stage pipeline (products, sum, reciprocal multiply, shift, output
//   select), with the saturation quotient worked out two bits per stage
//   alongside in stages 2 to 5.
// Reset and stalls
//   rst_n clears the pipeline valid bits and loads the register defaults.
//   The receiver cannot stall; every result appears exactly once.
module rgb_to_gray_pixel_converter_top
    import rgbg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // request channel
    input  logic                    start,
    output logic                    busy,
    input  logic [PIX_W-1:0]        red,
    input  logic [PIX_W-1:0]        green,
    input  logic [PIX_W-1:0]        blue,
    input  logic signed [VAL_W-1:0] sample,
    input  logic                    frame_end,
    // configuration channel
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [VAL_W-1:0]        cfg_data,
    // result channel
    output logic                    result_valid,
    output logic signed [VAL_W-1:0] value,
    output logic                    frame_end_out
);

    // Configuration registers
    logic [MODE_W-1:0]        mode_reg;
    logic [GAIN_W-1:0]        gain_red_reg;
    logic [GAIN_W-1:0]        gain_green_reg;
    logic [GAIN_W-1:0]        gain_blue_reg;
    logic signed [VAL_W-1:0]  clamp_min_reg;
    logic signed [VAL_W-1:0]  clamp_max_reg;

    // Pipeline valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // Stage 1
    logic [PROD_W-1:0]        prod_r_reg, prod_g_reg, prod_b_reg;
    logic [PROD_W-1:0]        prod_r_next, prod_g_next, prod_b_next;
    div_t                     div1_reg, div1_next;
    logic signed [VAL_W-1:0]  scal1_reg, scal1_next;
    logic                     fe1_reg;
    logic [PIX_W-1:0]         mx, mn, diff;

    // Stage 2
    logic [SUM_W-1:0]         sum2_reg, sum2_next;
    div_t                     div2_reg, div2_next;
    logic signed [VAL_W-1:0]  scal2_reg;
    logic                     fe2_reg;

    // Stage 3
    logic [MUL_W-1:0]         mul3_reg, mul3_next;
    div_t                     div3_reg, div3_next;
    logic signed [VAL_W-1:0]  scal3_reg;
    logic                     fe3_reg;

    // Stage 4
    logic [INT_W-1:0]         int4_reg, int4_next;
    div_t                     div4_reg, div4_next;
    logic signed [VAL_W-1:0]  scal4_reg;
    logic                     fe4_reg;

    // Stage 5 (output)
    logic signed [VAL_W-1:0]  value_reg, value_next;
    logic                     fe5_reg;
    div_t                     div5;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_INTENSITY;
            gain_red_reg   <= 10'd299;
            gain_green_reg <= 10'd587;
            gain_blue_reg  <= 10'd114;
            clamp_min_reg  <= '0;
            clamp_max_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MODE:       mode_reg       <= cfg_data[MODE_W-1:0];
                REG_GAIN_RED:   gain_red_reg   <= cfg_data[GAIN_W-1:0];
                REG_GAIN_GREEN: gain_green_reg <= cfg_data[GAIN_W-1:0];
                REG_GAIN_BLUE:  gain_blue_reg  <= cfg_data[GAIN_W-1:0];
                REG_CLAMP_MIN:  clamp_min_reg  <= cfg_data;
                REG_CLAMP_MAX:  clamp_max_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Stage 1: weighted products, max/min, saturation numerator, clamp
    always_comb
    begin
        prod_r_next = PROD_W'(red)   * PROD_W'(gain_red_reg);
        prod_g_next = PROD_W'(green) * PROD_W'(gain_green_reg);
        prod_b_next = PROD_W'(blue)  * PROD_W'(gain_blue_reg);

        mx = (red > green) ? red : green;
        mx = (mx > blue) ? mx : blue;
        mn = (red < green) ? red : green;
        mn = (mn < blue) ? mn : blue;
        diff = mx - mn;

        // diff * 255 as a shift and subtract
        div1_next.rem = {diff, {PIX_W{1'b0}}} - REM_W'(diff);
        div1_next.quo = '0;
        div1_next.dvs = mx;

        // clamp only when the bounds form a proper range
        scal1_next = sample;
        if (clamp_min_reg < clamp_max_reg)
        begin
            if (sample < clamp_min_reg)
                scal1_next = clamp_min_reg;
            else if (sample > clamp_max_reg)
                scal1_next = clamp_max_reg;
        end
    end

    // Stage 2: intensity sum, quotient bits 7 and 6
    assign sum2_next = SUM_W'(prod_r_reg) + SUM_W'(prod_g_reg) + SUM_W'(prod_b_reg);
    assign div2_next = div_step(div_step(div1_reg, 3'd7), 3'd6);

    // Stage 3: multiply by reciprocal of 1000, quotient bits 5 and 4
    assign mul3_next = MUL_W'(sum2_reg) * MUL_W'(RECIP_1000);
    assign div3_next = div_step(div_step(div2_reg, 3'd5), 3'd4);

    // Stage 4: reciprocal shift, quotient bits 3 and 2
    assign int4_next = mul3_reg[RECIP_SHIFT+INT_W-1:RECIP_SHIFT];
    assign div4_next = div_step(div_step(div3_reg, 3'd3), 3'd2);

    // Stage 5: quotient bits 1 and 0, mode select
    assign div5 = div_step(div_step(div4_reg, 3'd1), 3'd0);

    always_comb
    begin
        case (mode_reg)
            MODE_SATURATION:
            begin
                // black pixel gives zero saturation
                if (div4_reg.dvs == '0)
                    value_next = '0;
                else
                    value_next = VAL_W'(div5.quo);
            end
            MODE_SCALAR:
                value_next = scal4_reg;
            default:
                value_next = VAL_W'(int4_reg);
        endcase
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prod_r_reg <= prod_r_next;
        prod_g_reg <= prod_g_next;
        prod_b_reg <= prod_b_next;
        div1_reg   <= div1_next;
        scal1_reg  <= scal1_next;
        fe1_reg    <= frame_end;

        sum2_reg   <= sum2_next;
        div2_reg   <= div2_next;
        scal2_reg  <= scal1_reg;
        fe2_reg    <= fe1_reg;

        mul3_reg   <= mul3_next;
        div3_reg   <= div3_next;
        scal3_reg  <= scal2_reg;
        fe3_reg    <= fe2_reg;

        int4_reg   <= int4_next;
        div4_reg   <= div4_next;
        scal4_reg  <= scal3_reg;
        fe4_reg    <= fe3_reg;

        value_reg  <= value_next;
        fe5_reg    <= fe4_reg;
    end

    assign result_valid  = v5_reg;
    assign value         = value_reg;
    assign frame_end_out = fe5_reg;

endmodule

// File: src/rgbg_checker.sv
// Checker: port-level timing properties of the pixel converter, bound to the top level
module rgbg_checker
    import rgbg_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    frame_end,
    input logic                    result_valid,
    input logic                    frame_end_out
);

    // every request gives a strobe after the fixed latency
    a_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY result_valid)
        else $error("request without result after pipeline latency");

    // no strobe without a request
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LATENCY !result_valid)
        else $error("result strobe without matching request");

    // frame end marker follows its pixel
    a_frame_end_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY (frame_end_out == $past(frame_end, LATENCY)))
        else $error("frame end flag does not match its request");

endmodule

bind rgb_to_gray_pixel_converter_top rgbg_checker u_rgbg_checker (.*);

// File: verif/rgb_to_gray_pixel_converter_checker.sv
// Checker: tracks register writes, predicts each converted pixel and compares the results
module rgb_to_gray_pixel_converter_checker
    import rgbg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic [PIX_W-1:0]        red,
    input  logic [PIX_W-1:0]        green,
    input  logic [PIX_W-1:0]        blue,
    input  logic signed [VAL_W-1:0] sample,
    input  logic                    frame_end,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [VAL_W-1:0]        cfg_data,
    input  logic                    result_valid,
    input  logic signed [VAL_W-1:0] value,
    input  logic                    frame_end_out,
    output int                      errors,
    output int                      pending,
    output int                      checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    frame_end;
    } pixel_out_t;

    // Shadow copy of the block's registers
    logic [MODE_W-1:0]       cur_mode;
    logic [GAIN_W-1:0]       k_red;
    logic [GAIN_W-1:0]       k_green;
    logic [GAIN_W-1:0]       k_blue;
    logic signed [VAL_W-1:0] lim_lo;
    logic signed [VAL_W-1:0] lim_hi;

    // Converted pixels still owed by the block, oldest first
    pixel_out_t              expected_pixels[$];

    // Converted value of one pixel under the current register settings
    function automatic logic signed [VAL_W-1:0] convert_pixel(
        input logic [PIX_W-1:0]        r,
        input logic [PIX_W-1:0]        g,
        input logic [PIX_W-1:0]        b,
        input logic signed [VAL_W-1:0] s
    );
        int unsigned             weighted;
        int unsigned             hi_c;
        int unsigned             lo_c;
        logic signed [VAL_W-1:0] clipped;
        weighted = 32'(r) * 32'(k_red) + 32'(g) * 32'(k_green) + 32'(b) * 32'(k_blue);
        hi_c     = (r > g) ? r : g;
        hi_c     = (hi_c > b) ? hi_c : b;
        lo_c     = (r < g) ? r : g;
        lo_c     = (lo_c < b) ? lo_c : b;
        clipped  = s;
        case (cur_mode)
            MODE_SATURATION:
            begin
                // black pixel has no saturation
                if (hi_c == 0)
                    return '0;
                return VAL_W'((((hi_c - lo_c) * 32'd255 * 32'd1024) / hi_c) / 32'd1024);
            end
            MODE_SCALAR:
            begin
                // clamp only applies when the bounds are properly ordered
                if (lim_lo < lim_hi)
                begin
                    if (clipped < lim_lo)
                        clipped = lim_lo;
                    if (clipped > lim_hi)
                        clipped = lim_hi;
                end
                return clipped;
            end
            // intensity, and the unused mode code behaves the same way
            default:
                return VAL_W'(weighted / 32'd1000);
        endcase
    endfunction

    // Watch all three channels on the rising edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_out_t want;
        pixel_out_t due;
        if (!rst_n)
        begin
            cur_mode = MODE_INTENSITY;
            k_red    = GAIN_W'(299);
            k_green  = GAIN_W'(587);
            k_blue   = GAIN_W'(114);
            lim_lo   = '0;
            lim_hi   = '0;
            expected_pixels.delete();
            pending  = 0;
        end
        else
        begin
            // compare a result against the oldest outstanding pixel
            if (result_valid)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected result: value %0d frame_end_out %0b",
                           value, frame_end_out);
                    errors++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    checked++;
                    if (value !== want.value)
                    begin
                        $error("value: expected %0d, got %0d", want.value, value);
                        errors++;
                    end
                    if (frame_end_out !== want.frame_end)
                    begin
                        $error("frame_end_out: expected %0b, got %0b",
                               want.frame_end, frame_end_out);
                        errors++;
                    end
                end
            end

            // predict each accepted request
            if (start && !busy)
            begin
                due.value     = convert_pixel(red, green, blue, sample);
                due.frame_end = frame_end;
                expected_pixels.push_back(due);
            end

            // follow register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MODE:       cur_mode = cfg_data[MODE_W-1:0];
                    REG_GAIN_RED:   k_red    = cfg_data[GAIN_W-1:0];
                    REG_GAIN_GREEN: k_green  = cfg_data[GAIN_W-1:0];
                    REG_GAIN_BLUE:  k_blue   = cfg_data[GAIN_W-1:0];
                    REG_CLAMP_MIN:  lim_lo   = cfg_data;
                    REG_CLAMP_MAX:  lim_hi   = cfg_data;
                    default:        ;
                endcase
            end

            pending = expected_pixels.size();
        end
    end

endmodule

// File: verif/rgb_to_gray_pixel_converter_top_tb.sv
// Testbench top: drives pixel requests and register writes into the converter, gives the verdict
module rgb_to_gray_pixel_converter_top_tb
    import rgbg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [MODE_W-1:0]       MODE_UNUSED = 2'd3;
    localparam logic signed [VAL_W-1:0] VAL_MIN     = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX     = {1'b0, {(VAL_W-1){1'b1}}};
    localparam int                      CYCLE_LIMIT = 400000;
    localparam int                      PHASES      = 24;
    localparam int                      PHASE_ITEMS = 80;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [PIX_W-1:0]        red;
    logic [PIX_W-1:0]        green;
    logic [PIX_W-1:0]        blue;
    logic signed [VAL_W-1:0] sample;
    logic                    frame_end;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [IDX_W-1:0]        cfg_index;
    logic [VAL_W-1:0]        cfg_data;
    logic                    result_valid;
    logic signed [VAL_W-1:0] value;
    logic                    frame_end_out;

    int                      errors;
    int                      pending;
    int                      checked;
    int                      cycle_count;

    // Stimulus bookkeeping
    logic [MODE_W-1:0]       mode_now;
    logic signed [VAL_W-1:0] clamp_lo;
    logic signed [VAL_W-1:0] clamp_hi;
    int                      sent;
    int                      frame_ends;
    int                      settings;
    int                      per_mode[4];

    rgb_to_gray_pixel_converter_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .sample        (sample),
        .frame_end     (frame_end),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .value         (value),
        .frame_end_out (frame_end_out)
    );

    rgb_to_gray_pixel_converter_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .sample        (sample),
        .frame_end     (frame_end),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .value         (value),
        .frame_end_out (frame_end_out),
        .errors        (errors),
        .pending       (pending),
        .checked       (checked)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("rgb_to_gray_pixel_converter_top: mismatch");
            $finish;
        end
    end

    // One pixel request, held until the block takes it
    task automatic send_pixel(
        input logic [PIX_W-1:0]        r,
        input logic [PIX_W-1:0]        g,
        input logic [PIX_W-1:0]        b,
        input logic signed [VAL_W-1:0] s,
        input logic                    fe
    );
        @(negedge clk);
        red       <= r;
        green     <= g;
        blue      <= b;
        sample    <= s;
        frame_end <= fe;
        start     <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
        per_mode[mode_now]++;
        if (fe)
            frame_ends++;
    endtask

    // Drop start for an idle gap of length n, with junk on the payload
    task automatic idle_for(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            start     <= 1'b0;
            red       <= PIX_W'($urandom());
            green     <= PIX_W'($urandom());
            blue      <= PIX_W'($urandom());
            sample    <= VAL_W'({1'($urandom_range(0, 1)), $urandom()});
            frame_end <= 1'($urandom_range(0, 1));
            repeat (n - 1)
                @(negedge clk);
        end
    endtask

    // Stop requests and wait until every result is back
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Register write; only called while nothing is in flight
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_MODE)
            mode_now = data[MODE_W-1:0];
        if (idx == REG_CLAMP_MIN)
            clamp_lo = data;
        if (idx == REG_CLAMP_MAX)
            clamp_hi = data;
    endtask

    // Idle length: mostly none or short, occasionally long
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [PIX_W-1:0] next_colour();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 3)
            return '0;
        if (pick < 6)
            return '1;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    function automatic logic signed [VAL_W-1:0] full_value();
        return VAL_W'({1'($urandom_range(0, 1)), $urandom()});
    endfunction

    // Sample: near the clamp bounds, extremes, small, or anything
    function automatic logic signed [VAL_W-1:0] next_sample();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 3)
            return clamp_lo + $signed(VAL_W'($urandom_range(0, 4))) - 33'sd2;
        if (pick < 6)
            return clamp_hi + $signed(VAL_W'($urandom_range(0, 4))) - 33'sd2;
        if (pick < 8)
            return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
        if (pick < 11)
            return $signed(VAL_W'($urandom_range(0, 20))) - 33'sd10;
        return full_value();
    endfunction

    function automatic logic [VAL_W-1:0] pick_gain();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return VAL_W'(1000);
        if (pick == 2)
            return VAL_W'(1023);
        return VAL_W'($urandom_range(0, 1023));
    endfunction

    // Clamp bounds: full range, equal, reversed, narrow or ordered random
    task automatic pick_clamp();
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] hi;
        int                      pick;
        a    = full_value();
        b    = full_value();
        pick = $urandom_range(0, 9);
        if (pick < 2)
        begin
            lo = VAL_MIN;
            hi = VAL_MAX;
        end
        else if (pick < 3)
        begin
            lo = a;
            hi = a;
        end
        else if (pick < 4)
        begin
            lo = (a > b) ? a : b;
            hi = (a > b) ? b : a;
        end
        else if (pick < 6)
        begin
            lo = $signed(VAL_W'($urandom_range(0, 200))) - 33'sd100;
            hi = lo + $signed(VAL_W'($urandom_range(1, 50)));
        end
        else
        begin
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
        end
        write_reg(REG_CLAMP_MIN, lo);
        write_reg(REG_CLAMP_MAX, hi);
    endtask

    // New random register setting between phases
    task automatic pick_setting();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            write_reg(REG_MODE, VAL_W'(MODE_INTENSITY));
        else if (pick < 6)
            write_reg(REG_MODE, VAL_W'(MODE_SATURATION));
        else if (pick < 9)
            write_reg(REG_MODE, VAL_W'(MODE_SCALAR));
        else
            write_reg(REG_MODE, VAL_W'(MODE_UNUSED));
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_GAIN_RED, pick_gain());
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_GAIN_GREEN, pick_gain());
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_GAIN_BLUE, pick_gain());
        if ($urandom_range(0, 1) == 0)
            pick_clamp();
        settings++;
    endtask

    // Main sequence
    initial
    begin : stimulus
        logic [PIX_W-1:0] c;
        logic             no_gaps;
        rst_n     = 1'b0;
        start     = 1'b0;
        red       = '0;
        green     = '0;
        blue      = '0;
        sample    = '0;
        frame_end = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MODE;
        cfg_data  = '0;
        mode_now  = MODE_INTENSITY;
        clamp_lo  = '0;
        clamp_hi  = '0;
        settings  = 1;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Intensity with the reset gains: colour extremes
        send_pixel(8'd0, 8'd0, 8'd0, VAL_MAX, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, VAL_MIN, 1'b1);
        send_pixel(8'd255, 8'd0, 8'd0, '0, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd0, '0, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd255, -33'sd1, 1'b1);

        // Saturation: black, grey, pure colour, small values
        drain();
        write_reg(REG_MODE, VAL_W'(MODE_SATURATION));
        settings++;
        send_pixel(8'd0, 8'd0, 8'd0, '0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, '0, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd0, VAL_MAX, 1'b1);
        send_pixel(8'd1, 8'd0, 8'd0, '0, 1'b0);
        send_pixel(8'd255, 8'd254, 8'd0, '0, 1'b0);
        send_pixel(8'd3, 8'd2, 8'd1, '0, 1'b0);

        // Scalar with the clamp inactive (bounds equal after reset)
        drain();
        write_reg(REG_MODE, VAL_W'(MODE_SCALAR));
        settings++;
        send_pixel(8'd255, 8'd255, 8'd255, VAL_MIN, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, VAL_MAX, 1'b1);
        send_pixel(8'd255, 8'd0, 8'd255, -33'sd1, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, '0, 1'b0);

        // Scalar with an active clamp around zero
        drain();
        write_reg(REG_CLAMP_MIN, -33'sd100);
        write_reg(REG_CLAMP_MAX, 33'sd100);
        settings++;
        send_pixel(8'd0, 8'd0, 8'd0, -33'sd101, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 33'sd101, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 33'sd50, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, VAL_MIN, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, VAL_MAX, 1'b1);

        // Unused mode code with the largest gains, then zero gains
        drain();
        write_reg(REG_MODE, VAL_W'(MODE_UNUSED));
        write_reg(REG_GAIN_RED, VAL_W'(1023));
        write_reg(REG_GAIN_GREEN, VAL_W'(1023));
        write_reg(REG_GAIN_BLUE, VAL_W'(1023));
        settings++;
        send_pixel(8'd255, 8'd255, 8'd255, VAL_MAX, 1'b0);
        send_pixel(8'd1, 8'd1, 8'd1, '0, 1'b1);
        drain();
        write_reg(REG_GAIN_RED, '0);
        write_reg(REG_GAIN_GREEN, '0);
        write_reg(REG_GAIN_BLUE, '0);
        settings++;
        send_pixel(8'd255, 8'd255, 8'd255, '0, 1'b0);
        send_pixel(8'd128, 8'd64, 8'd32, '0, 1'b1);

        // Random phases, each under a fresh register setting
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            pick_setting();
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // grey pixel
                    c = next_colour();
                    send_pixel(c, c, c, next_sample(), ($urandom_range(0, 15) == 0));
                end
                else
                begin
                    send_pixel(next_colour(), next_colour(), next_colour(), next_sample(),
                               ($urandom_range(0, 15) == 0));
                end
                if (!no_gaps)
                    idle_for(gap_len());
            end
        end

        drain();
        repeat (LATENCY + 4)
            @(negedge clk);

        $display("covered %0d pixels under %0d register settings (%0d frame ends)",
                 sent, settings, frame_ends);
        $display("by mode: intensity %0d, saturation %0d, scalar %0d, unused code %0d; %0d compared",
                 per_mode[MODE_INTENSITY], per_mode[MODE_SATURATION],
                 per_mode[MODE_SCALAR], per_mode[MODE_UNUSED], checked);
        if (errors == 0 && pending == 0)
            $display("rgb_to_gray_pixel_converter_top: match");
        else
            $display("rgb_to_gray_pixel_converter_top: mismatch");
        $finish;
    end

endmodule

// File: rgb_to_gray_pixel_converter_top.f
src/rgbg_pkg.sv
src/rgb_to_gray_pixel_converter_top.sv
src/rgbg_checker.sv
verif/rgb_to_gray_pixel_converter_checker.sv
verif/rgb_to_gray_pixel_converter_top_tb.sv
